/* src/bss_pkg.sv */
//------------------------------------------------------------------------------
// bss_pkg
// Shared widths, register indexes, cell control type and pattern helpers for
// the byte signature scanner.
//------------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   localparam int MAX_PATTERN    = 16;
   localparam int WIN_IDX_BITS   = $clog2(MAX_PATTERN);
   localparam int PLEN_BITS      = 5;
   localparam int DATA_BITS      = 8;
   localparam int OFFSET_BITS    = 32;
   localparam int CFG_BITS       = 64;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LEN  = 2'd2;

   localparam logic [PLEN_BITS-1:0] PLEN_MIN = PLEN_BITS'(1);
   localparam logic [PLEN_BITS-1:0] PLEN_MAX = PLEN_BITS'(MAX_PATTERN);

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   function automatic logic [PLEN_BITS-1:0] effective_length(
      input logic [PLEN_BITS-1:0] len
   );
      logic [PLEN_BITS-1:0] n;
      n = len;
      if (n == '0) begin
         n = PLEN_MIN;
      end
      if (n > PLEN_MAX) begin
         n = PLEN_MAX;
      end
      return n;
   endfunction

   function automatic logic [DATA_BITS-1:0] pattern_byte(
      input logic [CFG_BITS-1:0]     low,
      input logic [CFG_BITS-1:0]     high,
      input logic [WIN_IDX_BITS-1:0] idx
   );
      logic [2*CFG_BITS-1:0] pat;
      pat = {high, low};
      return pat[idx*DATA_BITS +: DATA_BITS];
   endfunction

endpackage

`default_nettype wire

/* src/bss_channels.sv */
//------------------------------------------------------------------------------
// bss channels
// Valid/ready transaction channels for scanned bytes and scan results.
//------------------------------------------------------------------------------
`default_nettype none

interface bss_req_if import bss_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bss_rsp_if import bss_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [OFFSET_BITS-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

/* src/bss_cell.sv */
//------------------------------------------------------------------------------
// bss_cell
// One window byte: holds a byte, passes it on to the next cell on a shift and
// compares the arriving byte against its pattern byte.
//------------------------------------------------------------------------------
`default_nettype none

module bss_cell import bss_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [DATA_BITS-1:0] prev_byte,
   input  wire logic [DATA_BITS-1:0] expected,
   input  wire logic                 enable,
   output logic      [DATA_BITS-1:0] byte_out,
   output logic                      hit
);

   logic [DATA_BITS-1:0] byte_ff;
   logic [DATA_BITS-1:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) begin
         byte_in = '0;
      end else if (ctrl.shift) begin
         byte_in = prev_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   // compare the byte this cell will hold after the shift
   assign hit      = !enable || (prev_byte == expected);
   assign byte_out = byte_ff;

endmodule

`default_nettype wire

/* src/byte_signature_scanner.sv */
//------------------------------------------------------------------------------
// byte_signature_scanner
// Finds the first occurrence of a 1 to 16 byte pattern in a byte region.
//------------------------------------------------------------------------------
// Takes one byte per clock on the request channel; the region ends at a
// transaction with last_byte set. A row of 16 window cells shifts the bytes
// along and compares all pattern positions in the same cycle, so a byte is
// accepted every cycle while the response side keeps up. A response (found=1
// with the start offset, or found=0 at the end of a region without a match)
// sits in the output register from the cycle after the deciding byte. Bytes
// after a match are dropped until the end of the region. The offset saturates
// at all ones. Pattern registers must be written through the csr port only
// while no region is in flight; the block itself does not enforce this.
//------------------------------------------------------------------------------
`default_nettype none

module byte_signature_scanner import bss_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bss_req_if.sink                        req_if,
   bss_rsp_if.source                      rsp_if,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_write_data
);

   logic [CFG_BITS-1:0]    pat_low_ff,  pat_low_in;
   logic [CFG_BITS-1:0]    pat_high_ff, pat_high_in;
   logic [PLEN_BITS-1:0]   pat_len_ff,  pat_len_in;
   logic [OFFSET_BITS-1:0] count_ff,    count_in;
   logic                   done_ff,     done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;

   logic                   accept;
   logic [PLEN_BITS-1:0]   eff_len;
   logic [OFFSET_BITS-1:0] count_next;
   logic                   match;
   cell_ctrl_type          cell_ctrl;
   logic [DATA_BITS-1:0]   cell_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_hit;

   // configuration
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_in  = csr_write_data;
            CSR_PATTERN_HIGH: pat_high_in = csr_write_data;
            CSR_PATTERN_LEN:  pat_len_in  = csr_write_data[PLEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign eff_len = effective_length(pat_len_ff);

   // window cells
   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         localparam logic [PLEN_BITS-1:0] POS = PLEN_BITS'(k);
         logic [PLEN_BITS-1:0] pidx;
         logic [DATA_BITS-1:0] chain_in;

         assign pidx = eff_len - PLEN_MIN - POS;
         if (k == 0) begin : g_head
            assign chain_in = req_if.data_byte;
         end else begin : g_body
            assign chain_in = cell_byte[k-1];
         end

         bss_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .prev_byte (chain_in),
            .expected  (pattern_byte(pat_low_ff, pat_high_ff, pidx[WIN_IDX_BITS-1:0])),
            .enable    (POS < eff_len),
            .byte_out  (cell_byte[k]),
            .hit       (cell_hit[k])
         );
      end
   endgenerate

   // scan control
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign count_next   = (count_ff == OFFSET_MAX) ? count_ff : count_ff + 1'b1;
   assign match        = (count_next >= OFFSET_BITS'(eff_len)) && (&cell_hit);

   always_comb begin
      count_in        = count_ff;
      done_in         = done_ff;
      cell_ctrl.shift = 1'b0;
      cell_ctrl.clear = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in    = rsp_found_ff;
      rsp_offset_in   = rsp_offset_ff;
      if (accept) begin
         if (done_ff) begin
            if (req_if.last_byte) begin
               count_in        = '0;
               done_in         = 1'b0;
               cell_ctrl.clear = 1'b1;
            end
         end else begin
            cell_ctrl.shift = 1'b1;
            count_in        = count_next;
            if (match) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_offset_in = (count_next == OFFSET_MAX) ? OFFSET_MAX
                                                          : count_next - OFFSET_BITS'(eff_len);
               done_in       = 1'b1;
            end else if (req_if.last_byte) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_offset_in = '0;
            end
            if (req_if.last_byte) begin
               count_in        = '0;
               done_in         = 1'b0;
               cell_ctrl.clear = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= PLEN_MIN;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         pat_len_ff   <= pat_len_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.match_offset = rsp_offset_ff;

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.last_byte |=> count_ff == '0 && !done_ff)
      else $error("region state not cleared after last byte");

   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> rsp_valid_ff && rsp_found_ff)
      else $error("match flagged without a found response");

   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("no-match response with nonzero offset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_valid_ff && !rsp_if.ready)
      else $error("request stalled while output register free");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the byte signature scanner.
//------------------------------------------------------------------------------
// Bytes are offered as regions on the request channel. At each accepted
// transaction a scan model in the bench updates its window and byte count and
// queues the expected response. The monitor checks every response, one field
// at a time, against the oldest queued entry. The pattern registers are
// rewritten only while the scanner is idle. Each setting is a separate phase:
// the extreme lengths, an out-of-range length, all-ones and all-zero
// patterns, and a two-symbol alphabet that gives overlapping near matches.
//------------------------------------------------------------------------------

module tb;
   import bss_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SETTLE_CYCLES     = 4;
   localparam int END_CYCLES        = 10;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT       = 250000;
   localparam int RANDOM_PHASES     = 11;
   localparam int PHASE_BYTES       = 150;

   typedef struct {
      logic [DATA_BITS-1:0] data_byte;
      logic                 last_byte;
   } scan_byte_type;

   typedef struct {
      logic                   found;
      logic [OFFSET_BITS-1:0] match_offset;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CFG_BITS-1:0]       csr_write_data   = '0;

   bss_req_if req_ch ();
   bss_rsp_if rsp_ch ();

   byte_signature_scanner uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch.sink),
      .rsp_if           (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scan model state
   logic [CFG_BITS-1:0]    sig_low     = '0;
   logic [CFG_BITS-1:0]    sig_high    = '0;
   logic [PLEN_BITS-1:0]   sig_len_raw = PLEN_BITS'(1);
   logic [DATA_BITS-1:0]   scan_window [MAX_PATTERN];
   logic [OFFSET_BITS-1:0] scan_count  = '0;
   logic                   scan_done   = 1'b0;

   scan_byte_type   byte_queue [$];
   scan_result_type scan_results_due [$];

   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   req_gap        = 0;
   int   rsp_wait       = 0;
   logic src_gaps_on    = 1'b0;
   logic sink_gaps_on   = 1'b0;
   logic alphabet_mode  = 1'b0;
   logic stall_request  = 1'b0;
   logic rsp_blocked    = 1'b0;

   initial begin
      foreach (scan_window[k]) scan_window[k] = '0;
   end

   function automatic int scan_len();
      if (sig_len_raw == '0) return 1;
      if (sig_len_raw > MAX_PATTERN) return MAX_PATTERN;
      return int'(sig_len_raw);
   endfunction

   function automatic logic [DATA_BITS-1:0] signature_byte(input int k);
      logic [2*CFG_BITS-1:0] sig;
      sig = {sig_high, sig_low};
      return sig[k*DATA_BITS +: DATA_BITS];
   endfunction

   function automatic void clear_scan();
      foreach (scan_window[k]) scan_window[k] = '0;
      scan_count = '0;
      scan_done  = 1'b0;
   endfunction

   function automatic void advance_scan(input logic [DATA_BITS-1:0] din,
                                        input logic is_last);
      scan_result_type r;
      int              plen;
      int              k;
      logic            hit;
      if (scan_done) begin
         if (is_last) clear_scan();
         return;
      end
      for (k = MAX_PATTERN - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
      scan_window[0] = din;
      if (scan_count != OFFSET_MAX) scan_count = scan_count + 1'b1;
      plen = scan_len();
      hit  = (scan_count >= OFFSET_BITS'(plen));
      for (k = 0; k < plen; k++)
         if (scan_window[plen-1-k] != signature_byte(k)) hit = 1'b0;
      if (hit) begin
         r.found        = 1'b1;
         r.match_offset = (scan_count == OFFSET_MAX) ? OFFSET_MAX
                                                     : scan_count - OFFSET_BITS'(plen);
         scan_results_due.push_back(r);
         if (is_last) clear_scan();
         else scan_done = 1'b1;
      end else if (is_last) begin
         r.found        = 1'b0;
         r.match_offset = '0;
         scan_results_due.push_back(r);
         clear_scan();
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      scan_byte_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            advance_scan(req_ch.data_byte, req_ch.last_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               it = byte_queue.pop_front();
               req_ch.data_byte <= it.data_byte;
               req_ch.last_byte <= it.last_byte;
               req_ch.valid     <= 1'b1;
               req_gap = src_gaps_on ? $urandom_range(0, 12) : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      scan_result_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (scan_results_due.size() == 0) begin
               $display("%0t: unexpected response, found=%0b match_offset=%0d",
                        $time, rsp_ch.found, rsp_ch.match_offset);
               mismatch_count++;
            end else begin
               e = scan_results_due.pop_front();
               if (rsp_ch.found !== e.found) begin
                  $display("%0t: found mismatch, expected %0b, actual %0b",
                           $time, e.found, rsp_ch.found);
                  mismatch_count++;
               end
               if (rsp_ch.match_offset !== e.match_offset) begin
                  $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                           $time, e.match_offset, rsp_ch.match_offset);
                  mismatch_count++;
               end
            end
            rsp_wait = sink_gaps_on ? $urandom_range(0, 12) : 0;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
         end
         rsp_ch.ready <= (rsp_wait == 0) && !rsp_blocked;
      end
   end

   // long response hold-off
   always begin
      wait (stall_request);
      @(posedge clock);
      rsp_blocked <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      rsp_blocked <= 1'b0;
      stall_request = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time,
                  scan_results_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_ch.valid || scan_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PATTERN_LOW) sig_low = value;
      else if (idx == CSR_PATTERN_HIGH) sig_high = value;
      else if (idx == CSR_PATTERN_LEN) sig_len_raw = value[PLEN_BITS-1:0];
   endtask

   function automatic void queue_byte(input logic [DATA_BITS-1:0] d, input logic l);
      scan_byte_type it;
      it.data_byte = d;
      it.last_byte = l;
      byte_queue.push_back(it);
   endfunction

   // region of random bytes, mostly with the pattern (or its head) planted
   task automatic queue_region(input int n_bytes, input int pause_at);
      logic [DATA_BITS-1:0] region_data [0:127];
      int plen;
      int at;
      int k;
      plen = scan_len();
      for (k = 0; k < n_bytes; k++)
         region_data[k] = (alphabet_mode || $urandom_range(0, 3) == 0)
                          ? signature_byte($urandom_range(0, plen - 1))
                          : DATA_BITS'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 6) begin
         at = $urandom_range(0, n_bytes - 1);
         for (k = 0; k < plen && at + k < n_bytes; k++)
            region_data[at+k] = signature_byte(k);
      end
      for (k = 0; k < n_bytes; k++) begin
         if (k == pause_at) wait_idle();
         queue_byte(region_data[k], k == n_bytes - 1);
      end
   endtask

   initial begin
      int                   phase;
      int                   bytes_left;
      int                   region_len;
      int                   k;
      logic                 paused;
      logic [PLEN_BITS-1:0] len_raw;
      logic [CFG_BITS-1:0]  lo;
      logic [CFG_BITS-1:0]  hi;
      logic [CFG_BITS-1:0]  len_word;

      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
      paused           = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: single zero byte; bytes after a match are dropped
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h5A, 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h7F, 1'b1);
      wait_idle();

      // length zero acts as one; unmapped index must not change anything
      write_reg(CSR_PATTERN_LOW, 64'h0123_4567_89AB_CDFF);
      write_reg(CSR_PATTERN_HIGH, 64'hFEDC_BA98_7654_3210);
      write_reg(CSR_PATTERN_LEN, '0);
      write_reg(CSR_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // length above 16 clamps to 16
      write_reg(CSR_PATTERN_LOW, 64'h0706_0504_0302_0100);
      write_reg(CSR_PATTERN_LEN, 64'd20);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h02, 1'b1);
      wait_idle();

      // zero pattern longer than the region: cleared window must not match
      write_reg(CSR_PATTERN_LOW, '0);
      write_reg(CSR_PATTERN_HIGH, '0);
      write_reg(CSR_PATTERN_LEN, 64'd4);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      wait_idle();

      // pattern cut by the region end, then whole on the final byte
      write_reg(CSR_PATTERN_LOW, 64'h4433_2211);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b0);
      queue_byte(8'h33, 1'b1);
      queue_byte(8'h44, 1'b1);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b0);
      queue_byte(8'h33, 1'b0);
      queue_byte(8'h44, 1'b1);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0:       len_raw = PLEN_BITS'(1);
            1:       len_raw = PLEN_BITS'(16);
            2:       len_raw = PLEN_BITS'($urandom_range(2, 15));
            3:       len_raw = '0;
            4:       len_raw = PLEN_BITS'($urandom_range(17, 31));
            default: len_raw = PLEN_BITS'($urandom_range(1, 16));
         endcase
         alphabet_mode = 1'($urandom_range(0, 1));
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         if (phase == 1) begin
            lo = '1;
            hi = '1;
         end else if (phase == 7) begin
            lo = '0;
            hi = '0;
         end else if (alphabet_mode) begin
            for (k = 0; k < 8; k++) begin
               lo[k*8 +: 8] = $urandom_range(0, 1) ? 8'h3C : 8'hC3;
               hi[k*8 +: 8] = $urandom_range(0, 1) ? 8'h3C : 8'hC3;
            end
         end
         len_word = $urandom_range(0, 1) ? ({$urandom, $urandom} & ~64'h1F) : '0;
         write_reg(CSR_PATTERN_LOW, lo);
         write_reg(CSR_PATTERN_HIGH, hi);
         write_reg(CSR_PATTERN_LEN, len_word | CFG_BITS'(len_raw));
         if ($urandom_range(0, 2) == 0) write_reg(CSR_UNMAPPED, {$urandom, $urandom});

         src_gaps_on  = (phase == 0) ? 1'b0 : (phase == 3) ? 1'b1
                                            : 1'($urandom_range(0, 1));
         sink_gaps_on = (phase == 0) ? 1'b0 : (phase == 3) ? 1'b1
                                            : 1'($urandom_range(0, 1));

         if (phase == 0) begin
            // short regions while the response side is held: fills the scanner
            stall_request = 1'b1;
            for (k = 0; k < 60; k++) queue_region($urandom_range(1, 2), -1);
         end

         bytes_left = PHASE_BYTES;
         while (bytes_left > 0) begin
            region_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 2 * scan_len() + 8);
            if (phase == 2 && !paused && region_len > 3) begin
               paused = 1'b1;
               queue_region(region_len, region_len / 2);
            end else begin
               queue_region(region_len, -1);
            end
            bytes_left -= region_len;
         end
         wait_idle();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
src/bss_pkg.sv
src/bss_channels.sv
src/bss_cell.sv
src/byte_signature_scanner.sv
sim/tb.sv
